[hdl/cal_pkg.sv]
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and constants for the compacting array list.
// ----------------------------------------------------------------------------
package cal_pkg;

    // Sizing
    localparam int LIST_DEPTH = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Fixed field widths
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int ICOUNT_W = 7;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_FIRST  = 3'd1,
        KIND_NEXT   = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RM_HEAD,
        S_SHIFT
    } t_state;

endpackage

[hdl/compacting_array_list.sv]
// ----------------------------------------------------------------------------
// compacting_array_list
// Ordered list held in one RAM, with a read cursor and compaction on remove.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  command   | start / busy           | i_kind, i_data_value
//  result    | o_valid (1-cycle pulse) | o_status, o_data_out, o_item_count
//
//  Insert, clear, unknown kinds and rejected commands: result registered in
//  the cycle after the transfer, busy stays low. First and next: one RAM read,
//  result through the RAM output and result registers. Remove: one read of the
//  cursor entry, then one RAM read and write per later entry moved down.
//  busy is high while a read or the compaction loop is running.
//  Synchronous active-low reset empties the list and drops the cursor; the
//  RAM contents are not cleared. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module compacting_array_list (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cal_pkg::KIND_W-1:0]      i_kind,
    input  logic [cal_pkg::DATA_WIDTH-1:0]  i_data_value,
    output logic                            o_valid,
    output logic [cal_pkg::STATUS_W-1:0]    o_status,
    output logic [cal_pkg::DATA_WIDTH-1:0]  o_data_out,
    output logic [cal_pkg::ICOUNT_W-1:0]    o_item_count
);
    import cal_pkg::*;

    // Control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_cur_vld, n_cur_vld;
    logic [ADDR_W-1:0]   r_cur, n_cur;
    logic [ADDR_W-1:0]   r_idx, n_idx;

    // Result registers
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [DATA_WIDTH-1:0] r_data, n_data;

    // RAM port signals
    logic                  w_we;
    logic [ADDR_W-1:0]     w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [ADDR_W-1:0]     w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    // Decode helpers
    logic                w_accept;
    t_kind               w_kind;
    logic [CNT_W-1:0]    w_next_pos;
    logic                w_next_ok;
    logic                w_rm_ok;
    logic                w_full;
    logic                w_more_head;
    logic                w_more_shift;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_kind   = t_kind'(i_kind);

    assign w_next_pos   = r_cur_vld ? (CNT_W'(r_cur) + CNT_W'(1)) : '0;
    assign w_next_ok    = (w_next_pos < r_count);
    assign w_rm_ok      = r_cur_vld && (CNT_W'(r_cur) < r_count);
    assign w_full       = (r_count >= CNT_W'(LIST_DEPTH));
    assign w_more_head  = ((CNT_W'(r_cur) + CNT_W'(1)) < r_count);
    assign w_more_shift = ((CNT_W'(r_idx) + CNT_W'(2)) < r_count);

    // Entry store
    cal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (w_kind == KIND_FIRST && r_count != '0) begin
                        n_state = S_READ;
                    end else if (w_kind == KIND_NEXT && w_next_ok) begin
                        n_state = S_READ;
                    end else if (w_kind == KIND_REMOVE && w_rm_ok) begin
                        n_state = S_RM_HEAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ:    n_state = S_IDLE;
            S_RM_HEAD: n_state = w_more_head ? S_SHIFT : S_IDLE;
            S_SHIFT:   n_state = w_more_shift ? S_SHIFT : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_count   = r_count;
        n_cur_vld = r_cur_vld;
        n_cur     = r_cur;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_data    = r_data;
        w_we      = 1'b0;
        w_waddr   = r_count[ADDR_W-1:0];
        w_wdata   = i_data_value;
        w_raddr   = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_data   = '0;
                    unique case (w_kind)
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        KIND_FIRST: begin
                            if (r_count == '0) begin
                                n_status = ST_NONE;
                            end else begin
                                // result comes back from the RAM next cycle
                                n_valid   = 1'b0;
                                w_raddr   = '0;
                                n_cur_vld = 1'b1;
                                n_cur     = '0;
                            end
                        end
                        KIND_NEXT: begin
                            if (!w_next_ok) begin
                                n_status = ST_NONE;
                            end else begin
                                n_valid   = 1'b0;
                                w_raddr   = w_next_pos[ADDR_W-1:0];
                                n_cur_vld = 1'b1;
                                n_cur     = w_next_pos[ADDR_W-1:0];
                            end
                        end
                        KIND_REMOVE: begin
                            if (!w_rm_ok) begin
                                n_status = ST_NONE;
                            end else begin
                                n_valid = 1'b0;
                                w_raddr = r_cur;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count   = '0;
                            n_cur_vld = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_READ: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_data   = w_rdata;
            end

            S_RM_HEAD: begin
                // removed entry arrives; start moving later entries down
                n_data   = w_rdata;
                n_status = ST_OK;
                n_idx    = r_cur;
                w_raddr  = r_cur + ADDR_W'(1);
                if (!w_more_head) begin
                    n_valid   = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    n_cur_vld = (r_cur != '0);
                    n_cur     = r_cur - ADDR_W'(1);
                end
            end

            S_SHIFT: begin
                // entry idx+1 is on the read port: write it to idx
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                w_raddr = r_idx + ADDR_W'(2);
                n_idx   = r_idx + ADDR_W'(1);
                if (!w_more_shift) begin
                    n_valid   = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    n_cur_vld = (r_cur != '0);
                    n_cur     = r_cur - ADDR_W'(1);
                end
            end

            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cur_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cur_vld <= n_cur_vld;
            r_valid   <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_data   <= n_data;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_data_out   = r_data;
    assign o_item_count = ICOUNT_W'(r_count);

endmodule

[hdl/cal_ram.sv]
// ----------------------------------------------------------------------------
// cal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
